/* rtl/text_console_scroller_macros.svh */
// Assertion macros used by the console datapath module.
`ifndef TEXT_CONSOLE_SCROLLER_MACROS_SVH
`define TEXT_CONSOLE_SCROLLER_MACROS_SVH

`ifndef SYNTH
`define TCS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("console assertion failed");
`define TCS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("console assertion failed");
`else
`define TCS_ASSERT(lbl, clk, rst_n, prop)
`define TCS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/tcs_pkg.sv */
`timescale 1ns / 1ps

package tcs_pkg;

    localparam int DEF_SCREEN_WIDTH  = 80;
    localparam int DEF_SCREEN_HEIGHT = 25;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int LIN_W  = 12;
    localparam int CPOS_W = 11;
    localparam int CELL_W = 16;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_PLACE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    localparam logic [7:0] NEWLINE_CODE     = 8'd10;
    localparam logic [7:0] SPACE_CODE       = 8'd32;
    localparam logic [7:0] TEXT_COLOR_RESET = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

    localparam logic [1:0] FILL_RESET = 2'd0;
    localparam logic [1:0] FILL_BLANK = 2'd1;
    localparam logic [1:0] FILL_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [7:0]       char_code;
        logic [7:0]       cell_color;
        logic [COL_W-1:0] pos_col;
        logic [ROW_W-1:0] pos_row;
    } req_t;

    typedef struct packed {
        logic [7:0]        read_char;
        logic [7:0]        read_color;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [CPOS_W-1:0] cursor_pos;
    } result_t;

    typedef struct packed {
        logic       latch;
        logic       exec;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       copy_rd;
        logic       copy_wr;
        logic       fill_wr;
        logic [1:0] fill_sel;
        logic       out_load;
        logic       out_direct;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       scroll_needed;
        logic       cnt_copy_last;
        logic       cnt_cell_last;
        logic       out_free;
    } status_t;

endpackage

/* rtl/tcs_ctrl.sv */
`timescale 1ns / 1ps

module tcs_ctrl
    import tcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] ST_RFILL  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_SCR_RD = 3'd3;
    localparam logic [2:0] ST_SCR_WR = 3'd4;
    localparam logic [2:0] ST_BFILL  = 3'd5;
    localparam logic [2:0] ST_CFILL  = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RFILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_RFILL:
            begin
                cmd.fill_wr  = 1'b1;
                cmd.fill_sel = FILL_RESET;
                cmd.cnt_inc  = 1'b1;
                if (status.cnt_cell_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.req_type == REQ_CLEAR)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_CFILL;
                end
                else if (status.scroll_needed)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_SCR_RD;
                end
                else if (status.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_direct = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCR_RD:
            begin
                cmd.copy_rd = 1'b1;
                state_next  = ST_SCR_WR;
            end
            ST_SCR_WR:
            begin
                cmd.copy_wr = 1'b1;
                cmd.cnt_inc = 1'b1;
                state_next  = status.cnt_copy_last ? ST_BFILL : ST_SCR_RD;
            end
            ST_BFILL:
            begin
                cmd.fill_wr  = 1'b1;
                cmd.fill_sel = FILL_BLANK;
                cmd.cnt_inc  = 1'b1;
                if (status.cnt_cell_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_CFILL:
            begin
                cmd.fill_wr  = 1'b1;
                cmd.fill_sel = FILL_CLEAR;
                cmd.cnt_inc  = 1'b1;
                if (status.cnt_cell_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/tcs_datapath.sv */
`timescale 1ns / 1ps

`include "text_console_scroller_macros.svh"

module tcs_datapath
    import tcs_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_color_we,
    input  logic [7:0] text_color_wdata,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output result_t    rsp,
    input  cmd_t       cmd,
    output status_t    status
);

    localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COPY_LAST  = CELL_COUNT - SCREEN_WIDTH - 1;

    logic [7:0]        text_color_reg;
    req_t              req_reg;
    logic [COL_W-1:0]  cur_col_reg;
    logic [COL_W-1:0]  cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [ROW_W-1:0]  cur_row_next;
    logic [ADDR_W-1:0] cnt_reg;
    logic [CELL_W-1:0] rdata_reg;
    logic [CELL_W-1:0] rd_hold_reg;
    logic              out_valid_reg;
    result_t           out_data_reg;
    logic [CELL_W-1:0] mem [CELL_COUNT];

    logic              in_on_screen;
    logic [LIN_W-1:0]  in_lin;
    logic              l_on_screen;
    logic [LIN_W-1:0]  l_lin;
    logic [LIN_W-1:0]  cur_lin;
    logic [LIN_W-1:0]  next_lin;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [CELL_W-1:0] fill_cell;
    logic [CELL_W-1:0] rd_now;
    logic              newline;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic              wrap;
    logic              past;
    logic              out_free;
    result_t           exec_result;
    result_t           hold_result;

    assign in_on_screen = ({1'b0, req.pos_col} < (COL_W + 1)'(SCREEN_WIDTH))
                       && ({1'b0, req.pos_row} < (ROW_W + 1)'(SCREEN_HEIGHT));
    assign in_lin = LIN_W'(req.pos_row) * LIN_W'(SCREEN_WIDTH) + LIN_W'(req.pos_col);

    assign l_on_screen = ({1'b0, req_reg.pos_col} < (COL_W + 1)'(SCREEN_WIDTH))
                      && ({1'b0, req_reg.pos_row} < (ROW_W + 1)'(SCREEN_HEIGHT));
    assign l_lin = LIN_W'(req_reg.pos_row) * LIN_W'(SCREEN_WIDTH)
                 + LIN_W'(req_reg.pos_col);

    assign cur_lin  = LIN_W'(cur_row_reg) * LIN_W'(SCREEN_WIDTH) + LIN_W'(cur_col_reg);
    assign next_lin = LIN_W'(cur_row_next) * LIN_W'(SCREEN_WIDTH) + LIN_W'(cur_col_next);

    assign newline = (req_reg.char_code == NEWLINE_CODE);
    assign col_inc = {1'b0, cur_col_reg} + 1'b1;
    assign row_inc = {1'b0, cur_row_reg} + 1'b1;
    assign wrap    = newline || (col_inc >= (COL_W + 1)'(SCREEN_WIDTH));
    assign past    = (row_inc >= (ROW_W + 1)'(SCREEN_HEIGHT));

    always_comb
    begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (cmd.exec)
        begin
            case (req_reg.req_type)
                REQ_PUT:
                begin
                    if (wrap)
                    begin
                        cur_col_next = '0;
                        cur_row_next = past ? ROW_W'(SCREEN_HEIGHT - 1) : row_inc[ROW_W-1:0];
                    end
                    else
                    begin
                        cur_col_next = col_inc[COL_W-1:0];
                    end
                end
                REQ_CLEAR:
                begin
                    cur_col_next = '0;
                    cur_row_next = '0;
                end
                default:
                begin
                    cur_col_next = cur_col_reg;
                    cur_row_next = cur_row_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (cmd.fill_sel)
            FILL_RESET: fill_cell = RESET_CELL;
            FILL_BLANK: fill_cell = {8'h00, SPACE_CODE};
            FILL_CLEAR: fill_cell = {text_color_reg, SPACE_CODE};
            default:    fill_cell = RESET_CELL;
        endcase
    end

    always_comb
    begin
        mem_we = 1'b0;
        waddr  = cnt_reg;
        wdata  = fill_cell;
        if (cmd.exec)
        begin
            if (req_reg.req_type == REQ_PUT && !newline)
            begin
                mem_we = 1'b1;
                waddr  = cur_lin[ADDR_W-1:0];
                wdata  = {text_color_reg, req_reg.char_code};
            end
            else if (req_reg.req_type == REQ_PLACE && l_on_screen)
            begin
                mem_we = 1'b1;
                waddr  = l_lin[ADDR_W-1:0];
                wdata  = {req_reg.cell_color, req_reg.char_code};
            end
        end
        else if (cmd.copy_wr)
        begin
            mem_we = 1'b1;
            wdata  = rdata_reg;
        end
        else if (cmd.fill_wr)
        begin
            mem_we = 1'b1;
        end
    end

    always_comb
    begin
        if (cmd.copy_rd)
        begin
            rd_addr = cnt_reg + ADDR_W'(SCREEN_WIDTH);
        end
        else if (in_on_screen)
        begin
            rd_addr = in_lin[ADDR_W-1:0];
        end
        else
        begin
            rd_addr = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign rd_now = (req_reg.req_type == REQ_READ && l_on_screen) ? rdata_reg : '0;

    always_comb
    begin
        exec_result.read_char  = rd_now[7:0];
        exec_result.read_color = rd_now[15:8];
        exec_result.cursor_col = cur_col_next;
        exec_result.cursor_row = cur_row_next;
        exec_result.cursor_pos = next_lin[CPOS_W-1:0];
        hold_result.read_char  = rd_hold_reg[7:0];
        hold_result.read_color = rd_hold_reg[15:8];
        hold_result.cursor_col = cur_col_reg;
        hold_result.cursor_row = cur_row_reg;
        hold_result.cursor_pos = cur_lin[CPOS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= req;
        end
        if (cmd.exec)
        begin
            rd_hold_reg <= rd_now;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= cmd.out_direct ? exec_result : hold_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= TEXT_COLOR_RESET;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (text_color_we)
            begin
                text_color_reg <= text_color_wdata;
            end
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    assign status.req_type      = req_reg.req_type;
    assign status.scroll_needed = (req_reg.req_type == REQ_PUT) && wrap && past;
    assign status.cnt_copy_last = (cnt_reg == ADDR_W'(COPY_LAST));
    assign status.cnt_cell_last = (cnt_reg == ADDR_W'(CELL_COUNT - 1));
    assign status.out_free      = out_free;

    `TCS_ASSERT(a_cursor_on_screen, clk, rst_n, ({1'b0, cur_col_reg} < (COL_W + 1)'(SCREEN_WIDTH)) && ({1'b0, cur_row_reg} < (ROW_W + 1)'(SCREEN_HEIGHT)))
    `TCS_ASSERT(a_no_result_overwrite, clk, rst_n, cmd.out_load |-> out_free)
    `TCS_ASSERT(a_write_in_range, clk, rst_n, mem_we |-> ({1'b0, waddr} < (ADDR_W + 1)'(CELL_COUNT)))
    `TCS_ASSERT(a_load_shows_valid, clk, rst_n, cmd.out_load |=> rsp_valid)

endmodule

/* rtl/text_console_scroller.sv */
`timescale 1ns / 1ps

// Text console with a SCREEN_WIDTH x SCREEN_HEIGHT cell store in a single-port-write,
// single-port-read memory. Putting a character without a scroll, placing a cell and
// reading a cell each pass through an accept state, which also reads the addressed cell,
// and then an execute state that writes the memory or returns the read data. A character
// that steps past the last row adds a scroll in which each moved cell needs a memory read
// and then a write, the new bottom row is then written one cell a cycle, and the result
// is then loaded. A clear adds the fill writes and then the result load. After reset the
// block fills the screen with grey spaces and accepts no request until that pass is done;
// the text color register may be written at any time while no request is in flight. A
// finished result is held in an output register, so the next request can be accepted
// while it waits to be taken; if that register is still full when the next result is
// ready, the block waits until it is taken before accepting another request.
module text_console_scroller
    import tcs_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_color_we,
    input  logic [7:0] text_color_wdata,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output result_t    rsp
);

    cmd_t    cmd;
    status_t status;

    tcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tcs_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .text_color_we    (text_color_we),
        .text_color_wdata (text_color_wdata),
        .req              (req),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .rsp              (rsp),
        .cmd              (cmd),
        .status           (status)
    );

endmodule
